FILE: rtl/core/aec_pkg.sv
// aec_pkg: shared types, constants and tables of the ambisonic coefficient encoder
// holds payload structs, cordic arctangent table and the harmonic step sequence
// no dependencies
package aec_pkg;

   typedef struct packed {
      logic signed [15:0] azimuth;
      logic signed [15:0] elevation;
   } req_type;

   typedef struct packed {
      logic [3:0]         channel;
      logic signed [23:0] coefficient;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       order;
      logic             mode_3d;
      logic [15:0]      gain;
      logic [3:0][15:0] weight;
   } cfg_type;

   // q30 sines and cosines of the five angles, only the sine for twice the elevation
   typedef struct packed {
      logic signed [31:0] ca;
      logic signed [31:0] sa;
      logic signed [31:0] c2a;
      logic signed [31:0] s2a;
      logic signed [31:0] c3a;
      logic signed [31:0] s3a;
      logic signed [31:0] ce;
      logic signed [31:0] se;
      logic signed [31:0] s2e;
   } trig_type;

   localparam int OPW          = 34;
   localparam int CORDIC_STEPS = 30;
   localparam int NUM_H        = 16;

   localparam logic signed [OPW-1:0] Q30_ONE     = 34'sd1073741824;
   localparam logic signed [OPW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [OPW-1:0] K_S32       = 34'sd929887697;
   localparam logic signed [OPW-1:0] K_S58       = 34'sd848867446;
   localparam logic signed [OPW-1:0] K_S152      = 34'sd2079292101;
   localparam logic signed [OPW-1:0] K_S38       = 34'sd657529896;

   // register indexes
   localparam logic [2:0] CSR_ORDER   = 3'd0;
   localparam logic [2:0] CSR_MODE_3D = 3'd1;
   localparam logic [2:0] CSR_GAIN    = 3'd2;
   localparam logic [2:0] CSR_WEIGHT0 = 3'd3;
   localparam logic [2:0] CSR_WEIGHT1 = 3'd4;
   localparam logic [2:0] CSR_WEIGHT2 = 3'd5;
   localparam logic [2:0] CSR_WEIGHT3 = 3'd6;

   // operand sources of the harmonic sequencer
   localparam logic [4:0] SRC_ZERO = 5'd0;
   localparam logic [4:0] SRC_CA   = 5'd1;
   localparam logic [4:0] SRC_SA   = 5'd2;
   localparam logic [4:0] SRC_C2A  = 5'd3;
   localparam logic [4:0] SRC_S2A  = 5'd4;
   localparam logic [4:0] SRC_C3A  = 5'd5;
   localparam logic [4:0] SRC_S3A  = 5'd6;
   localparam logic [4:0] SRC_CE   = 5'd7;
   localparam logic [4:0] SRC_SE   = 5'd8;
   localparam logic [4:0] SRC_S2E  = 5'd9;
   localparam logic [4:0] SRC_CE2  = 5'd10;
   localparam logic [4:0] SRC_CE3  = 5'd11;
   localparam logic [4:0] SRC_F5   = 5'd12;
   localparam logic [4:0] SRC_F3   = 5'd13;
   localparam logic [4:0] SRC_T    = 5'd14;
   localparam logic [4:0] SRC_H1   = 5'd15;
   localparam logic [4:0] SRC_H3   = 5'd16;
   localparam logic [4:0] SRC_K32  = 5'd17;
   localparam logic [4:0] SRC_K58  = 5'd18;
   localparam logic [4:0] SRC_K152 = 5'd19;
   localparam logic [4:0] SRC_K38  = 5'd20;

   // destinations
   localparam logic [2:0] DST_CE2  = 3'd0;
   localparam logic [2:0] DST_CE3  = 3'd1;
   localparam logic [2:0] DST_SE2  = 3'd2;
   localparam logic [2:0] DST_T    = 3'd3;
   localparam logic [2:0] DST_H    = 3'd4;
   localparam logic [2:0] DST_HALF = 3'd5;

   localparam logic [4:0] LAST_STEP_3D = 5'd27;
   localparam logic [4:0] LAST_STEP_2D = 5'd8;

   typedef struct packed {
      logic [4:0] src_a;
      logic [4:0] src_b;
      logic [2:0] dst;
      logic [3:0] hidx;
   } step_type;

   function automatic step_type mk(input logic [4:0] a, input logic [4:0] b,
                                   input logic [2:0] d, input logic [3:0] h);
      step_type s;
      s.src_a = a;
      s.src_b = b;
      s.dst   = d;
      s.hidx  = h;
      return s;
   endfunction

   function automatic step_type harm_step(input logic [4:0] step, input logic mode_3d);
      step_type s;
      s = mk(SRC_ZERO, SRC_ZERO, DST_T, 4'd0);
      case (step)
         5'd0: s = mk(SRC_CE, SRC_CE, DST_CE2, 4'd0);
         5'd1: s = mk(SRC_CE2, SRC_CE, DST_CE3, 4'd0);
         5'd2: s = mk(SRC_SE, SRC_SE, DST_SE2, 4'd0);
         default: begin
            if (mode_3d) begin
               case (step)
                  5'd3:  s = mk(SRC_SA, SRC_CE, DST_H, 4'd1);
                  5'd4:  s = mk(SRC_CA, SRC_CE, DST_H, 4'd3);
                  5'd5:  s = mk(SRC_S2A, SRC_CE2, DST_T, 4'd0);
                  5'd6:  s = mk(SRC_K32, SRC_T, DST_H, 4'd4);
                  5'd7:  s = mk(SRC_SA, SRC_S2E, DST_T, 4'd0);
                  5'd8:  s = mk(SRC_K32, SRC_T, DST_H, 4'd5);
                  5'd9:  s = mk(SRC_CA, SRC_S2E, DST_T, 4'd0);
                  5'd10: s = mk(SRC_K32, SRC_T, DST_H, 4'd7);
                  5'd11: s = mk(SRC_C2A, SRC_CE2, DST_T, 4'd0);
                  5'd12: s = mk(SRC_K32, SRC_T, DST_H, 4'd8);
                  5'd13: s = mk(SRC_S3A, SRC_CE3, DST_T, 4'd0);
                  5'd14: s = mk(SRC_K58, SRC_T, DST_H, 4'd9);
                  5'd15: s = mk(SRC_S2A, SRC_SE, DST_T, 4'd0);
                  5'd16: s = mk(SRC_T, SRC_CE2, DST_T, 4'd0);
                  5'd17: s = mk(SRC_K152, SRC_T, DST_H, 4'd10);
                  5'd18: s = mk(SRC_H1, SRC_F5, DST_T, 4'd0);
                  5'd19: s = mk(SRC_K38, SRC_T, DST_H, 4'd11);
                  5'd20: s = mk(SRC_SE, SRC_F3, DST_HALF, 4'd12);
                  5'd21: s = mk(SRC_H3, SRC_F5, DST_T, 4'd0);
                  5'd22: s = mk(SRC_K38, SRC_T, DST_H, 4'd13);
                  5'd23: s = mk(SRC_C2A, SRC_SE, DST_T, 4'd0);
                  5'd24: s = mk(SRC_T, SRC_CE2, DST_T, 4'd0);
                  5'd25: s = mk(SRC_K152, SRC_T, DST_H, 4'd14);
                  5'd26: s = mk(SRC_C3A, SRC_CE3, DST_T, 4'd0);
                  5'd27: s = mk(SRC_K58, SRC_T, DST_H, 4'd15);
                  default: s = mk(SRC_ZERO, SRC_ZERO, DST_T, 4'd0);
               endcase
            end else begin
               case (step)
                  5'd3: s = mk(SRC_CA, SRC_CE, DST_H, 4'd1);
                  5'd4: s = mk(SRC_SA, SRC_CE, DST_H, 4'd2);
                  5'd5: s = mk(SRC_C2A, SRC_CE2, DST_H, 4'd3);
                  5'd6: s = mk(SRC_S2A, SRC_CE2, DST_H, 4'd4);
                  5'd7: s = mk(SRC_C3A, SRC_CE3, DST_H, 4'd5);
                  5'd8: s = mk(SRC_S3A, SRC_CE3, DST_H, 4'd6);
                  default: s = mk(SRC_ZERO, SRC_ZERO, DST_T, 4'd0);
               endcase
            end
         end
      endcase
      return s;
   endfunction

   function automatic logic [29:0] atan_tab(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'h20000000;
         5'd1:  v = 30'h12E4051E;
         5'd2:  v = 30'h09FB385B;
         5'd3:  v = 30'h051111D4;
         5'd4:  v = 30'h028B0D43;
         5'd5:  v = 30'h0145D7E1;
         5'd6:  v = 30'h00A2F61E;
         5'd7:  v = 30'h00517C55;
         5'd8:  v = 30'h0028BE53;
         5'd9:  v = 30'h00145F2F;
         5'd10: v = 30'h000A2F98;
         5'd11: v = 30'h000517CC;
         5'd12: v = 30'h00028BE6;
         5'd13: v = 30'h000145F3;
         5'd14: v = 30'h0000A2FA;
         5'd15: v = 30'h0000517D;
         5'd16: v = 30'h000028BE;
         5'd17: v = 30'h0000145F;
         5'd18: v = 30'h00000A30;
         5'd19: v = 30'h00000518;
         5'd20: v = 30'h0000028C;
         5'd21: v = 30'h00000146;
         5'd22: v = 30'h000000A3;
         5'd23: v = 30'h00000051;
         5'd24: v = 30'h00000029;
         5'd25: v = 30'h00000014;
         5'd26: v = 30'h0000000A;
         5'd27: v = 30'h00000005;
         5'd28: v = 30'h00000003;
         5'd29: v = 30'h00000001;
         default: v = 30'h0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/aec_front.sv
// aec_front: input side, turns directions into phases and queues them
// two-entry queue between the input channel and the cordic unit
// depends on aec_pkg
module aec_front #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  aec_pkg::req_type       req_data,
   output logic                   q_valid,
   output logic [ANGLE_WIDTH-1:0] q_az,
   output logic [ANGLE_WIDTH-1:0] q_el,
   input  logic                   q_pop
);
   import aec_pkg::*;

   logic [ANGLE_WIDTH-1:0] az_ff [2];
   logic [ANGLE_WIDTH-1:0] el_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic [31:0]            az_full, el_full;
   logic                   push;

   // phase keeps the top bits of a 32-bit turn
   assign az_full = {req_data.azimuth, 16'h0000};
   assign el_full = {req_data.elevation, 16'h0000};

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_az      = az_ff[rd_ptr_ff];
   assign q_el      = el_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         az_ff[wr_ptr_ff] <= az_full[31 -: ANGLE_WIDTH];
         el_ff[wr_ptr_ff] <= el_full[31 -: ANGLE_WIDTH];
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("direction queue count out of range");

endmodule

FILE: rtl/core/aec_cordic.sv
// aec_cordic: five-lane iterative cordic, one rotation step per cycle on all lanes
// lanes take azimuth, 2x, 3x azimuth, elevation and 2x elevation
// depends on aec_pkg
module aec_cordic #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [ANGLE_WIDTH-1:0] az_ph,
   input  logic [ANGLE_WIDTH-1:0] el_ph,
   output logic                   idle,
   output logic                   done,
   input  logic                   take,
   output aec_pkg::trig_type      trig
);
   import aec_pkg::*;

   localparam int LANES = 5;

   logic signed [OPW-1:0] x_ff [LANES];
   logic signed [OPW-1:0] y_ff [LANES];
   logic signed [OPW-1:0] z_ff [LANES];
   logic [LANES-1:0]      neg_ff;
   logic [4:0]            idx_ff;
   logic                  busy_ff, done_ff;
   logic [31:0]           pa32, pe32;
   logic [31:0]           ph [LANES];
   logic signed [OPW-1:0] atan_val;

   function automatic logic signed [31:0] finish(input logic signed [OPW-1:0] v,
                                                 input logic n);
      logic signed [OPW-1:0] r;
      r = v;
      if (v > Q30_ONE)
         r = Q30_ONE;
      if (v < -Q30_ONE)
         r = -Q30_ONE;
      if (n)
         r = -r;
      return r[31:0];
   endfunction

   assign pa32 = {az_ph, {(32-ANGLE_WIDTH){1'b0}}};
   assign pe32 = {el_ph, {(32-ANGLE_WIDTH){1'b0}}};

   always_comb begin
      ph[0] = pa32;
      ph[1] = pa32 << 1;
      ph[2] = pa32 + (pa32 << 1);
      ph[3] = pe32;
      ph[4] = pe32 << 1;
   end

   assign atan_val = {4'b0000, atan_tab(idx_ff)};
   assign idle     = !busy_ff && !done_ff;
   assign done     = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= 5'd0;
      end else begin
         if (start && idle) begin
            busy_ff <= 1'b1;
            idx_ff  <= 5'd0;
         end else if (busy_ff) begin
            idx_ff <= idx_ff + 5'd1;
            if (idx_ff == 5'(CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end else if (done_ff && take) begin
            done_ff <= 1'b0;
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic        neg;
      logic [31:0] adj;
      assign neg = ph[l][31] ^ ph[l][30];
      assign adj = neg ? (ph[l] + 32'h8000_0000) : ph[l];

      always_ff @(posedge clock) begin
         if (start && idle) begin
            // fold the half turn around zero, flip signs at the end
            neg_ff[l] <= neg;
            x_ff[l]   <= CORDIC_GAIN;
            y_ff[l]   <= '0;
            z_ff[l]   <= {{2{adj[31]}}, adj};
         end else if (busy_ff) begin
            if (!z_ff[l][OPW-1]) begin
               x_ff[l] <= x_ff[l] - (y_ff[l] >>> idx_ff);
               y_ff[l] <= y_ff[l] + (x_ff[l] >>> idx_ff);
               z_ff[l] <= z_ff[l] - atan_val;
            end else begin
               x_ff[l] <= x_ff[l] + (y_ff[l] >>> idx_ff);
               y_ff[l] <= y_ff[l] - (x_ff[l] >>> idx_ff);
               z_ff[l] <= z_ff[l] + atan_val;
            end
         end
      end
   end

   always_comb begin
      trig.ca  = finish(x_ff[0], neg_ff[0]);
      trig.sa  = finish(y_ff[0], neg_ff[0]);
      trig.c2a = finish(x_ff[1], neg_ff[1]);
      trig.s2a = finish(y_ff[1], neg_ff[1]);
      trig.c3a = finish(x_ff[2], neg_ff[2]);
      trig.s3a = finish(y_ff[2], neg_ff[2]);
      trig.ce  = finish(x_ff[3], neg_ff[3]);
      trig.se  = finish(y_ff[3], neg_ff[3]);
      trig.s2e = finish(y_ff[4], neg_ff[4]);
   end

   assert property (@(posedge clock) disable iff (reset) !(busy_ff && done_ff))
      else $error("cordic busy and done together");

   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && idx_ff == 5'(CORDIC_STEPS - 1)) |=> done_ff)
      else $error("cordic did not finish after the last step");

endmodule

FILE: rtl/core/aec_harm.sv
// aec_harm: harmonic sequencer, one rounded q30 multiply per step
// builds the unscaled harmonics from the cordic results, sixteen in 3D mode, seven in 2D
// depends on aec_pkg
module aec_harm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  mode_3d,
   input  aec_pkg::trig_type     trig,
   output logic                  idle,
   output logic                  done,
   input  logic                  take,
   output logic signed [33:0]    h [16]
);
   import aec_pkg::*;

   trig_type              trig_ff;
   logic                  mode_ff;
   logic [4:0]            step_ff;
   logic                  busy_ff, done_ff;
   logic signed [OPW-1:0] ce2_ff, ce3_ff, se2_ff, t_ff;
   logic signed [OPW-1:0] h_ff [NUM_H];
   step_type              uc;
   logic signed [OPW-1:0] op_a, op_b, f5, f3, h6_val, res;
   logic signed [2*OPW-1:0] prod, rnd;
   logic                  last_step;

   function automatic logic signed [OPW-1:0] sx(input logic signed [31:0] v);
      return {{(OPW-32){v[31]}}, v};
   endfunction

   function automatic logic signed [OPW-1:0] pick(input logic [4:0] code,
      input trig_type tr, input logic signed [OPW-1:0] ce2, input logic signed [OPW-1:0] ce3,
      input logic signed [OPW-1:0] f5v, input logic signed [OPW-1:0] f3v,
      input logic signed [OPW-1:0] t, input logic signed [OPW-1:0] h1,
      input logic signed [OPW-1:0] h3);
      logic signed [OPW-1:0] v;
      case (code)
         SRC_CA:   v = sx(tr.ca);
         SRC_SA:   v = sx(tr.sa);
         SRC_C2A:  v = sx(tr.c2a);
         SRC_S2A:  v = sx(tr.s2a);
         SRC_C3A:  v = sx(tr.c3a);
         SRC_S3A:  v = sx(tr.s3a);
         SRC_CE:   v = sx(tr.ce);
         SRC_SE:   v = sx(tr.se);
         SRC_S2E:  v = sx(tr.s2e);
         SRC_CE2:  v = ce2;
         SRC_CE3:  v = ce3;
         SRC_F5:   v = f5v;
         SRC_F3:   v = f3v;
         SRC_T:    v = t;
         SRC_H1:   v = h1;
         SRC_H3:   v = h3;
         SRC_K32:  v = K_S32;
         SRC_K58:  v = K_S58;
         SRC_K152: v = K_S152;
         SRC_K38:  v = K_S38;
         default:  v = '0;
      endcase
      return v;
   endfunction

   assign uc     = harm_step(step_ff, mode_ff);
   assign f5     = (se2_ff <<< 2) + se2_ff - Q30_ONE;
   assign f3     = (se2_ff <<< 2) + se2_ff - (Q30_ONE <<< 1) - Q30_ONE;
   assign h6_val = ((se2_ff <<< 1) + se2_ff - Q30_ONE) >>> 1;
   assign op_a   = pick(uc.src_a, trig_ff, ce2_ff, ce3_ff, f5, f3, t_ff, h_ff[1], h_ff[3]);
   assign op_b   = pick(uc.src_b, trig_ff, ce2_ff, ce3_ff, f5, f3, t_ff, h_ff[1], h_ff[3]);

   // round to nearest, ties upward
   assign prod = op_a * op_b;
   assign rnd  = (prod + 68'sd536870912) >>> 30;
   assign res  = rnd[OPW-1:0];

   assign last_step = (step_ff == (mode_ff ? LAST_STEP_3D : LAST_STEP_2D));
   assign idle      = !busy_ff && !done_ff;
   assign done      = done_ff;

   for (genvar i = 0; i < NUM_H; i++) begin : g_h
      assign h[i] = h_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 5'd0;
      end else begin
         if (start && idle) begin
            busy_ff <= 1'b1;
            step_ff <= 5'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 5'd1;
            if (last_step) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end else if (done_ff && take) begin
            done_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && idle) begin
         trig_ff <= trig;
         mode_ff <= mode_3d;
      end else if (busy_ff) begin
         case (uc.dst)
            DST_CE2:  ce2_ff <= res;
            DST_CE3:  ce3_ff <= res;
            DST_SE2:  se2_ff <= res;
            DST_T:    t_ff <= res;
            DST_H:    h_ff[uc.hidx] <= res;
            DST_HALF: h_ff[uc.hidx] <= res >>> 1;
            default:  t_ff <= res;
         endcase
         if (last_step) begin
            h_ff[0] <= Q30_ONE;
            if (mode_ff) begin
               h_ff[2] <= sx(trig_ff.se);
               h_ff[6] <= h6_val;
            end
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(busy_ff && done_ff))
      else $error("harmonic sequencer busy and done together");

endmodule

FILE: rtl/core/aec_emit.sv
// aec_emit: scales each harmonic by weight and gain, rounds, saturates, drives results
// three-stage pipeline that holds as a whole while the result is stalled
// depends on aec_pkg
module aec_emit #(
   parameter int MAX_ORDER = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [33:0]    h [16],
   input  aec_pkg::cfg_type      cfg,
   output logic                  idle,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output aec_pkg::rsp_type      rsp_data
);
   import aec_pkg::*;

   localparam int HN = (MAX_ORDER + 1) * (MAX_ORDER + 1);
   localparam int CW = $clog2(HN);

   logic signed [OPW-1:0] hs_ff [HN];
   logic [CW-1:0]         k_ff, last_ff;
   logic                  busy_ff, mode_ff;
   logic                  en;
   logic [1:0]            ord;
   logic [3:0]            last_idx, kk;
   logic [4:0]            kp1;
   logic [1:0]            lvl;
   logic signed [15:0]    w, g;
   logic signed [49:0]    p1_in, p1_ff;
   logic signed [65:0]    p2_in, p2_ff, rnd;
   logic [3:0]            ch1_ff, ch2_ff;
   logic                  l1_ff, l2_ff, v1_ff, v2_ff;
   logic signed [23:0]    sat;
   rsp_type               out_ff;
   logic                  out_v_ff;

   assign ord = (cfg.order > 2'(MAX_ORDER)) ? 2'(MAX_ORDER) : cfg.order;

   always_comb begin
      if (cfg.mode_3d) begin
         case (ord)
            2'd0: last_idx = 4'd0;
            2'd1: last_idx = 4'd3;
            2'd2: last_idx = 4'd8;
            default: last_idx = 4'd15;
         endcase
      end else begin
         last_idx = {1'b0, ord, 1'b0};
      end
   end

   assign kk  = 4'(k_ff);
   assign kp1 = {1'b0, kk} + 5'd1;

   always_comb begin
      if (mode_ff) begin
         if (kk == 4'd0)
            lvl = 2'd0;
         else if (kk < 4'd4)
            lvl = 2'd1;
         else if (kk < 4'd9)
            lvl = 2'd2;
         else
            lvl = 2'd3;
      end else begin
         lvl = kp1[2:1];
      end
   end

   assign w     = signed'(cfg.weight[lvl]);
   assign g     = signed'(cfg.gain);
   assign p1_in = hs_ff[k_ff] * w;
   assign p2_in = p1_ff * g;
   assign rnd   = (p2_ff + 66'sd137438953472) >>> 38;

   always_comb begin
      if (rnd > 66'sd8388607)
         sat = 24'sh7FFFFF;
      else if (rnd < -66'sd8388608)
         sat = 24'sh800000;
      else
         sat = rnd[23:0];
   end

   assign en        = !out_v_ff || !rsp_stall;
   assign idle      = !busy_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         out_v_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            k_ff    <= '0;
         end else if (en && busy_ff) begin
            k_ff <= k_ff + 1'b1;
            if (k_ff == last_ff)
               busy_ff <= 1'b0;
         end
         if (en) begin
            v1_ff    <= busy_ff;
            v2_ff    <= v1_ff;
            out_v_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         for (int i = 0; i < HN; i++)
            hs_ff[i] <= h[i];
         last_ff <= last_idx[CW-1:0];
         mode_ff <= cfg.mode_3d;
      end
      if (en) begin
         p1_ff  <= p1_in;
         ch1_ff <= kk;
         l1_ff  <= (k_ff == last_ff);
         p2_ff  <= p2_in;
         ch2_ff <= ch1_ff;
         l2_ff  <= l1_ff;
         out_ff.channel     <= ch2_ff;
         out_ff.coefficient <= sat;
         out_ff.last        <= l2_ff;
      end
   end

endmodule

FILE: rtl/core/ambisonic_encode_coefficients.sv
// Ambisonic encoder: each accepted direction (azimuth, elevation) yields one result per
// channel, ACN/SN3D spherical harmonics in 3D mode or circular harmonics in 2D mode,
// scaled by order weight and gain, rounded and saturated to Q7.16. Directions queue
// (two deep) ahead of a five-lane cordic; a harmonic sequencer then works through its
// steps on one shared multiplier, and the output pipeline gives one channel per cycle
// unless the result is stalled. The three parts overlap: the cordic takes the next
// queued direction once it has handed its results over to the harmonic sequencer.
module ambisonic_encode_coefficients #(
   parameter int MAX_ORDER   = 3,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  aec_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output aec_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_addr,
   input  logic [15:0]      csr_wdata
);
   import aec_pkg::*;

   cfg_type                cfg_ff;
   logic                   q_valid, q_pop;
   logic [ANGLE_WIDTH-1:0] q_az, q_el;
   logic                   cor_idle, cor_done;
   trig_type               trig;
   logic                   harm_idle, harm_done, harm_start;
   logic signed [33:0]     h [16];
   logic                   emit_idle, emit_start;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.order   <= 2'd1;
         cfg_ff.mode_3d <= 1'b1;
         cfg_ff.gain    <= 16'd4096;
         cfg_ff.weight  <= {4{16'd4096}};
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ORDER:   cfg_ff.order     <= csr_wdata[1:0];
            CSR_MODE_3D: cfg_ff.mode_3d   <= csr_wdata[0];
            CSR_GAIN:    cfg_ff.gain      <= csr_wdata;
            CSR_WEIGHT0: cfg_ff.weight[0] <= csr_wdata;
            CSR_WEIGHT1: cfg_ff.weight[1] <= csr_wdata;
            CSR_WEIGHT2: cfg_ff.weight[2] <= csr_wdata;
            CSR_WEIGHT3: cfg_ff.weight[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign q_pop      = q_valid && cor_idle;
   assign harm_start = cor_done && harm_idle;
   assign emit_start = harm_done && emit_idle;

   aec_front #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_az      (q_az),
      .q_el      (q_el),
      .q_pop     (q_pop)
   );

   aec_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (q_pop),
      .az_ph  (q_az),
      .el_ph  (q_el),
      .idle   (cor_idle),
      .done   (cor_done),
      .take   (harm_start),
      .trig   (trig)
   );

   aec_harm u_harm (
      .clock   (clock),
      .reset   (reset),
      .start   (harm_start),
      .mode_3d (cfg_ff.mode_3d),
      .trig    (trig),
      .idle    (harm_idle),
      .done    (harm_done),
      .take    (emit_start),
      .h       (h)
   );

   aec_emit #(.MAX_ORDER(MAX_ORDER)) u_emit (
      .clock     (clock),
      .reset     (reset),
      .start     (emit_start),
      .h         (h),
      .cfg       (cfg_ff),
      .idle      (emit_idle),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // channels of one direction leave in rising order, the next set restarts at zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last) |=>
      (!rsp_valid || rsp_data.channel == $past(rsp_data.channel) + 4'd1))
      else $error("channel sequence broken");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last) |=>
      (!rsp_valid || rsp_data.channel == 4'd0))
      else $error("channel set did not restart at zero");

   assert property (@(posedge clock) disable iff (reset)
      harm_start |-> !q_pop || !cor_idle || cor_done)
      else $error("cordic restarted while its results were handed over");

endmodule

FILE: tb/sv/aec_checker.sv
// aec_checker: predicts the channel gains of the ambisonic coefficient encoder and checks them
// watches the request, response and register ports; depends on aec_pkg
module aec_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  aec_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  aec_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_addr,
   input  logic [15:0]      csr_wdata,
   output int               errors,
   output int               dirs_done,
   output int               gains_seen
);
   import aec_pkg::*;

   localparam longint ONE30 = 64'sd1073741824;

   longint          arctan [30];
   logic [1:0]      cur_order;
   logic            cur_3d;
   longint          cur_gain;
   longint          cur_weight [4];
   rsp_type         gain_q [$];

   initial begin
      arctan = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
                 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
                 64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
                 64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
                 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
      errors     = 0;
      dirs_done  = 0;
      gains_seen = 0;
   end

   function automatic longint qmul(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint clamp1(input longint v);
      if (v > ONE30) return ONE30;
      if (v < -ONE30) return -ONE30;
      return v;
   endfunction

   task automatic sincos(input logic [31:0] ph, output longint c, output longint s);
      logic   flip;
      longint x, y, z, t;
      flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
      if (flip) ph = ph + 32'h80000000;
      z = longint'($signed(ph));
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - arctan[i];
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + arctan[i];
         end
         x = t;
      end
      x = clamp1(x);
      y = clamp1(y);
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   task automatic predict_gains(input req_type r);
      logic [31:0] pa, pe;
      longint      ca, sa, c2a, s2a, c3a, s3a, ce, se, c2e, s2e;
      longint      ce2, ce3, se2, f5, v;
      longint      h [16];
      int          n, lvl;
      rsp_type     g;
      pa = {r.azimuth, 16'h0};
      pe = {r.elevation, 16'h0};
      sincos(pa, ca, sa);
      sincos(pa * 2, c2a, s2a);
      sincos(pa * 3, c3a, s3a);
      sincos(pe, ce, se);
      sincos(pe * 2, c2e, s2e);
      ce2 = qmul(ce, ce);
      ce3 = qmul(ce2, ce);
      se2 = qmul(se, se);
      f5  = 5 * se2 - ONE30;
      foreach (h[i]) h[i] = 0;
      h[0] = ONE30;
      if (cur_3d) begin
         n = (cur_order + 1) * (cur_order + 1);
         h[1]  = qmul(sa, ce);
         h[2]  = se;
         h[3]  = qmul(ca, ce);
         h[4]  = qmul(K_S32, qmul(s2a, ce2));
         h[5]  = qmul(K_S32, qmul(sa, s2e));
         h[6]  = (3 * se2 - ONE30) >>> 1;
         h[7]  = qmul(K_S32, qmul(ca, s2e));
         h[8]  = qmul(K_S32, qmul(c2a, ce2));
         h[9]  = qmul(K_S58, qmul(s3a, ce3));
         h[10] = qmul(K_S152, qmul(qmul(s2a, se), ce2));
         h[11] = qmul(K_S38, qmul(qmul(sa, ce), f5));
         h[12] = qmul(se, 5 * se2 - 3 * ONE30) >>> 1;
         h[13] = qmul(K_S38, qmul(qmul(ca, ce), f5));
         h[14] = qmul(K_S152, qmul(qmul(c2a, se), ce2));
         h[15] = qmul(K_S58, qmul(c3a, ce3));
      end else begin
         n = 2 * cur_order + 1;
         h[1] = qmul(ca, ce);
         h[2] = qmul(sa, ce);
         h[3] = qmul(c2a, ce2);
         h[4] = qmul(s2a, ce2);
         h[5] = qmul(c3a, ce3);
         h[6] = qmul(s3a, ce3);
      end
      for (int k = 0; k < n; k++) begin
         if (cur_3d) lvl = (k == 0) ? 0 : (k < 4) ? 1 : (k < 9) ? 2 : 3;
         else lvl = (k + 1) / 2;
         v = (h[k] * cur_weight[lvl] * cur_gain + (64'sd1 <<< 37)) >>> 38;
         if (v > 64'sd8388607) v = 64'sd8388607;
         if (v < -64'sd8388608) v = -64'sd8388608;
         g.channel     = k[3:0];
         g.coefficient = v[23:0];
         g.last        = (k + 1 == n);
         gain_q.push_back(g);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cur_order = 2'd1;
         cur_3d    = 1'b1;
         cur_gain  = 4096;
         foreach (cur_weight[i]) cur_weight[i] = 4096;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            gains_seen++;
            if (gain_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer, expected none, got %p", $time, rsp_data);
            end else begin
               want = gain_q.pop_front();
               if (rsp_data.channel !== want.channel) begin
                  errors++;
                  $display("%0t: channel expected %0d got %0d", $time, want.channel,
                           rsp_data.channel);
               end
               if (rsp_data.coefficient !== want.coefficient) begin
                  errors++;
                  $display("%0t: coefficient (ch %0d) expected %0d got %0d", $time,
                           want.channel, want.coefficient, rsp_data.coefficient);
               end
               if (rsp_data.last !== want.last) begin
                  errors++;
                  $display("%0t: last (ch %0d) expected %0b got %0b", $time, want.channel,
                           want.last, rsp_data.last);
               end
               if (want.last) dirs_done++;
            end
         end
         if (req_valid && !req_stall) predict_gains(req_data);
         if (csr_we) begin
            case (csr_addr)
               CSR_ORDER:   cur_order = csr_wdata[1:0];
               CSR_MODE_3D: cur_3d = csr_wdata[0];
               CSR_GAIN:    cur_gain = longint'($signed(csr_wdata));
               CSR_WEIGHT0: cur_weight[0] = longint'($signed(csr_wdata));
               CSR_WEIGHT1: cur_weight[1] = longint'($signed(csr_wdata));
               CSR_WEIGHT2: cur_weight[2] = longint'($signed(csr_wdata));
               CSR_WEIGHT3: cur_weight[3] = longint'($signed(csr_wdata));
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: tb/sv/testbench.sv
// testbench: directions into the ambisonic coefficient encoder across several register settings
// depends on aec_pkg, ambisonic_encode_coefficients and aec_checker
module testbench;
   import aec_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [2:0] csr_addr;
   logic [15:0] csr_wdata;
   int         errors, dirs_done, gains_seen;
   int         dirs_sent;
   int         cycles;
   bit         sender_lazy, receiver_lazy, hold_off;

   ambisonic_encode_coefficients dut (.*);

   aec_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 2000000) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // response side: random hold-offs, one long one on request
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            hold_off = 0;
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
         end else begin
            n = receiver_lazy ? $urandom_range(0, 15) : 0;
            if (n != 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_dir(input logic [15:0] az, input logic [15:0] el);
      int gap;
      gap = sender_lazy ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data.azimuth   <= az;
      req_data.elevation <= el;
      do @(posedge clock); while (req_stall);
      dirs_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      wait (dirs_done == dirs_sent);
      repeat (100) @(posedge clock);
   endtask

   // write enable stays high across a burst, the caller drops it
   task automatic csr_write(input logic [2:0] a, input logic [15:0] d);
      csr_we    <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [1:0] ord, input logic m3, input logic [15:0] g,
                           input logic [15:0] w0, input logic [15:0] w1,
                           input logic [15:0] w2, input logic [15:0] w3);
      csr_write(CSR_ORDER, {14'h0, ord});
      csr_write(CSR_MODE_3D, {15'h0, m3});
      csr_write(CSR_GAIN, g);
      csr_write(CSR_WEIGHT0, w0);
      csr_write(CSR_WEIGHT1, w1);
      csr_write(CSR_WEIGHT2, w2);
      csr_write(CSR_WEIGHT3, w3);
      csr_we <= 1'b0;
   endtask

   task automatic random_dirs(input int count);
      logic [15:0] el;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0) el = 16'($urandom);
         else el = 16'($urandom_range(0, 32768) - 16384);
         send_dir(16'($urandom), el);
      end
   endtask

   initial begin
      logic [15:0] az_pts [6];
      logic [15:0] el_pts [6];
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_we        = 1'b0;
      csr_addr      = '0;
      csr_wdata     = '0;
      dirs_sent     = 0;
      sender_lazy   = 1;
      receiver_lazy = 1;
      hold_off      = 0;
      az_pts = '{16'h0000, 16'h4000, 16'hC000, 16'h8000, 16'h7FFF, 16'h2000};
      el_pts = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 16'h1555};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values first, then corners including out-of-range elevations
      for (int i = 0; i < 6; i++) send_dir(az_pts[i], el_pts[i]);
      drain();
      set_regs(2'd3, 1'b1, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000);
      for (int i = 0; i < 6; i++) send_dir(az_pts[i], el_pts[(i + 3) % 6]);
      drain();
      set_regs(2'd3, 1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      for (int i = 0; i < 6; i++) send_dir(az_pts[i], el_pts[i]);
      drain();
      set_regs(2'd0, 1'b1, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
      send_dir(16'h1234, 16'h0800);
      send_dir(16'hFFFF, 16'hFFFF);
      drain();

      // random settings, one phase with no idling, another with a long response hold-off
      for (int p = 0; p < 7; p++) begin
         set_regs(2'($urandom), 1'($urandom),
                  (p % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192)),
                  $urandom_range(0, 1) ? 16'($urandom) : 16'h1000, 16'($urandom),
                  $urandom_range(0, 1) ? 16'h8000 : 16'($urandom), 16'($urandom));
         sender_lazy   = (p != 2) && (p != 4);
         receiver_lazy = (p != 2);
         if (p == 4) hold_off = 1;
         random_dirs(50);
         drain();
      end
      sender_lazy   = 1;
      receiver_lazy = 1;

      wait (dirs_done == dirs_sent);
      repeat (200) @(posedge clock);
      $display("covered %0d directions, %0d channel gains, both modes, orders 0 to 3",
               dirs_sent, gains_seen);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/aec_pkg.sv
rtl/core/aec_front.sv
rtl/core/aec_cordic.sv
rtl/core/aec_harm.sv
rtl/core/aec_emit.sv
rtl/core/ambisonic_encode_coefficients.sv
tb/sv/aec_checker.sv
tb/sv/testbench.sv
